// File: hw/rtl/cfa_pkg.sv
// Shared package of the contiguous fit allocator: default sizes, register indexes,
// operation and result codes, and the command and status records of the controller.
// No dependencies.
package cfa_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int ADDR_BITS_DEF    = 16;
	localparam int ID_BITS_DEF      = 8;

	typedef enum logic [0:0] {
		REG_MEMORY_SIZE = 1'b0,
		REG_FIT_POLICY  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_PACK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOMEM    = 3'd1,
		ST_DUP      = 3'd2,
		ST_NOHOLE   = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_EMPTY    = 3'd5,
		ST_FULL     = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_ALC_FIRST,
		DP_SCAN_START,
		DP_ALC_EV,
		DP_ALC_LAST,
		DP_INS_START,
		DP_INS_MV,
		DP_INS_NEW,
		DP_IDX_INC,
		DP_SHF_MV,
		DP_DEC_CNT,
		DP_PCK_START,
		DP_PCK_MV,
		DP_RC_START,
		DP_RC_EV,
		DP_RC_END,
		DP_RESULT
	} dp_op_t;

	typedef enum logic [1:0] {
		RD_IDX    = 2'd0,
		RD_IDX_M1 = 2'd1,
		RD_IDX_P1 = 2'd2
	} rd_sel_t;

	typedef struct packed {
		dp_op_t  op;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    set_st;
		status_t st;
	} cfa_cmd_t;

	typedef struct packed {
		action_t action;
		logic    nomem;
		logic    empty;
		logic    full;
		logic    dup;
		logic    found;
		logic    last;
		logic    at_cnt;
		logic    ins_done;
		logic    shf_done;
		logic    match;
		logic    out_space;
	} cfa_stat_t;

endpackage

// File: hw/rtl/cfa_in_if.sv
// Request channel of the contiguous fit allocator: valid, ready and one operation.
// Depends on cfa_pkg.
interface cfa_in_if #(
	parameter int ADDR_BITS = cfa_pkg::ADDR_BITS_DEF,
	parameter int ID_BITS   = cfa_pkg::ID_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	cfa_pkg::action_t      action;
	logic [ID_BITS-1:0]    seg_id;
	logic [ADDR_BITS-1:0]  seg_size;

	modport source (output valid, action, seg_id, seg_size, input ready);
	modport sink   (input valid, action, seg_id, seg_size, output ready);
endinterface

// File: hw/rtl/cfa_out_if.sv
// Response channel of the contiguous fit allocator: valid, ready and one result.
// Depends on cfa_pkg.
interface cfa_out_if #(
	parameter int ADDR_BITS = cfa_pkg::ADDR_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	cfa_pkg::status_t      status;
	logic [ADDR_BITS-1:0]  seg_start;
	logic [ADDR_BITS-1:0]  seg_end;
	logic [ADDR_BITS-1:0]  free_left;

	modport source (output valid, status, seg_start, seg_end, free_left, input ready);
	modport sink   (input valid, status, seg_start, seg_end, free_left, output ready);
endinterface

// File: hw/rtl/cfa_ctrl.sv
// Controller of the contiguous fit allocator: one-hot state machine that walks the
// segment table through the datapath. Depends on cfa_pkg.
module cfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cfa_pkg::cfa_stat_t stat,
	output cfa_pkg::cfa_cmd_t  cmd
);
	import cfa_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE     = 18'b1 << 0,
		S_DISPATCH = 18'b1 << 1,
		S_ALC_RD   = 18'b1 << 2,
		S_ALC_EV   = 18'b1 << 3,
		S_ALC_LAST = 18'b1 << 4,
		S_ALC_DEC  = 18'b1 << 5,
		S_INS_RD   = 18'b1 << 6,
		S_INS_MV   = 18'b1 << 7,
		S_FRE_RD   = 18'b1 << 8,
		S_FRE_EV   = 18'b1 << 9,
		S_SHF_RD   = 18'b1 << 10,
		S_SHF_MV   = 18'b1 << 11,
		S_PCK_RD   = 18'b1 << 12,
		S_PCK_MV   = 18'b1 << 13,
		S_RC_INIT  = 18'b1 << 14,
		S_RC_RD    = 18'b1 << 15,
		S_RC_EV    = 18'b1 << 16,
		S_DONE     = 18'b1 << 17
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.op     = DP_NOP;
		cmd.rd_en  = 1'b0;
		cmd.rd_sel = RD_IDX;
		cmd.set_st = 1'b0;
		cmd.st     = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.action)
					ACT_ALLOC: begin
						if (stat.nomem) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_NOMEM;
							state_d    = S_DONE;
						end else if (stat.empty) begin
							cmd.op  = DP_ALC_FIRST;
							state_d = S_RC_INIT;
						end else begin
							cmd.op  = DP_SCAN_START;
							state_d = S_ALC_RD;
						end
					end
					ACT_FREE: begin
						if (stat.empty) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_EMPTY;
							state_d    = S_DONE;
						end else begin
							cmd.op  = DP_SCAN_START;
							state_d = S_FRE_RD;
						end
					end
					ACT_PACK: begin
						cmd.op  = DP_PCK_START;
						state_d = S_PCK_RD;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_ALC_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_ALC_EV;
			end
			S_ALC_EV: begin
				cmd.op  = DP_ALC_EV;
				state_d = stat.last ? S_ALC_LAST : S_ALC_RD;
			end
			S_ALC_LAST: begin
				cmd.op  = DP_ALC_LAST;
				state_d = S_ALC_DEC;
			end
			S_ALC_DEC: begin
				if (stat.dup) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_DUP;
					state_d    = S_DONE;
				end else if (stat.full) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_FULL;
					state_d    = S_DONE;
				end else if (!stat.found) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_NOHOLE;
					state_d    = S_DONE;
				end else begin
					cmd.op  = DP_INS_START;
					state_d = S_INS_RD;
				end
			end
			S_INS_RD: begin
				if (stat.ins_done) begin
					cmd.op  = DP_INS_NEW;
					state_d = S_RC_INIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_M1;
					state_d    = S_INS_MV;
				end
			end
			S_INS_MV: begin
				cmd.op  = DP_INS_MV;
				state_d = S_INS_RD;
			end
			S_FRE_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_FRE_EV;
			end
			S_FRE_EV: begin
				if (stat.match) begin
					state_d = S_SHF_RD;
				end else if (stat.last) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_NOTFOUND;
					state_d    = S_DONE;
				end else begin
					cmd.op  = DP_IDX_INC;
					state_d = S_FRE_RD;
				end
			end
			S_SHF_RD: begin
				if (stat.shf_done) begin
					cmd.op  = DP_DEC_CNT;
					state_d = S_RC_INIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_P1;
					state_d    = S_SHF_MV;
				end
			end
			S_SHF_MV: begin
				cmd.op  = DP_SHF_MV;
				state_d = S_SHF_RD;
			end
			S_PCK_RD: begin
				if (stat.at_cnt) begin
					state_d = S_RC_INIT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_PCK_MV;
				end
			end
			S_PCK_MV: begin
				cmd.op  = DP_PCK_MV;
				state_d = S_PCK_RD;
			end
			S_RC_INIT: begin
				cmd.op  = DP_RC_START;
				state_d = S_RC_RD;
			end
			S_RC_RD: begin
				if (stat.at_cnt) begin
					cmd.op  = DP_RC_END;
					state_d = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_RC_EV;
				end
			end
			S_RC_EV: begin
				cmd.op  = DP_RC_EV;
				state_d = S_RC_RD;
			end
			S_DONE: begin
				if (stat.out_space) begin
					cmd.op  = DP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !stat.out_space) |=> state_q == S_DONE)
		else $error("result dropped while the output register was occupied");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> state_q == S_DISPATCH)
		else $error("accepted request was not dispatched");

	a_dup_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALC_DEC && stat.dup) |=> state_q == S_DONE)
		else $error("duplicate id did not end the allocation");

endmodule

// File: hw/rtl/cfa_dpath.sv
// Datapath of the contiguous fit allocator: segment table memory, scan and move
// registers, space accounting, configuration and output register. Depends on cfa_pkg.
module cfa_dpath #(
	parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = cfa_pkg::ADDR_BITS_DEF,
	parameter int ID_BITS      = cfa_pkg::ID_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfa_pkg::cfg_reg_t     cfg_index,
	input  logic [ADDR_BITS-1:0]  cfg_wdata,
	input  cfa_pkg::action_t      req_action,
	input  logic [ID_BITS-1:0]    req_seg_id,
	input  logic [ADDR_BITS-1:0]  req_seg_size,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output cfa_pkg::status_t      rsp_status,
	output logic [ADDR_BITS-1:0]  rsp_seg_start,
	output logic [ADDR_BITS-1:0]  rsp_seg_end,
	output logic [ADDR_BITS-1:0]  rsp_free_left,
	input  cfa_pkg::cfa_cmd_t     cmd,
	output cfa_pkg::cfa_stat_t    stat
);
	import cfa_pkg::*;

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int MW = ID_BITS + 2 * ADDR_BITS;
	localparam int SW = ADDR_BITS + CW;
	localparam logic [ADDR_BITS-1:0] FIELD_MASK = ADDR_BITS'(32'h0000_FFFF);
	localparam logic [ID_BITS-1:0]   ID_MASK    = ID_BITS'(32'h0000_00FF);
	localparam logic [CW-1:0]        CNT_MAX    = CW'(MAX_SEGMENTS);

	logic [MW-1:0]        mem_q [MAX_SEGMENTS];
	logic [MW-1:0]        rdata_q;
	logic [MW-1:0]        wr_data;
	logic                 wr_en;
	logic [CW-1:0]        rd_idx;
	logic [IW-1:0]        rd_addr;
	logic [IW-1:0]        wr_addr;

	action_t              act_q;
	logic [ID_BITS-1:0]   id_q;
	logic [ADDR_BITS-1:0] size_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        pos_q;
	logic [ADDR_BITS-1:0] prev_q;
	logic                 dup_q;
	logic                 found_q;
	logic [ADDR_BITS-1:0] best_len_q;
	logic [ADDR_BITS-1:0] best_hs_q;
	logic [SW-1:0]        acc_q;
	logic                 awrap_q;
	logic [SW-1:0]        used_q;
	logic                 uwrap_q;
	logic [ADDR_BITS-1:0] mem_size_q;
	logic                 policy_q;
	status_t              res_status_q;
	logic [ADDR_BITS-1:0] res_start_q;
	logic [ADDR_BITS-1:0] res_end_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ADDR_BITS-1:0] out_start_q;
	logic [ADDR_BITS-1:0] out_end_q;
	logic [ADDR_BITS-1:0] out_free_q;

	logic [ID_BITS-1:0]   r_id;
	logic [ADDR_BITS-1:0] r_start;
	logic [ADDR_BITS-1:0] r_end;
	logic [ADDR_BITS-1:0] r_len;
	logic [ADDR_BITS-1:0] hole_he;
	logic [ADDR_BITS-1:0] hole_len;
	logic [CW-1:0]        hole_pos;
	logic                 hole_take;
	logic [ADDR_BITS-1:0] free_space;
	logic                 out_space;

	assign r_id    = rdata_q[MW-1 -: ID_BITS];
	assign r_start = rdata_q[2*ADDR_BITS-1 -: ADDR_BITS];
	assign r_end   = rdata_q[ADDR_BITS-1:0];
	assign r_len   = r_end - r_start;

	assign free_space = (uwrap_q || used_q >= SW'(mem_size_q)) ? '0
		: mem_size_q - used_q[ADDR_BITS-1:0];
	assign out_space  = !out_valid_q || rsp_ready;

	// A hole runs from the end of one segment to the start of the next, or to the
	// top of memory after the last one; a negative span is unusable.
	always_comb begin
		hole_he   = (cmd.op == DP_ALC_LAST) ? mem_size_q : r_start;
		hole_len  = hole_he - prev_q;
		hole_pos  = (cmd.op == DP_ALC_LAST) ? cnt_q - CW'(1) : idx_q - CW'(1);
		hole_take = (hole_he >= prev_q) && (size_q <= hole_len)
			&& (!found_q || (policy_q && hole_len < best_len_q));
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_IDX_M1: rd_idx = idx_q - CW'(1);
			RD_IDX_P1: rd_idx = idx_q + CW'(1);
			default:   rd_idx = idx_q;
		endcase
		rd_addr = rd_idx[IW-1:0];
		wr_addr = idx_q[IW-1:0];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = rdata_q;
		case (cmd.op)
			DP_ALC_FIRST: begin
				wr_en   = 1'b1;
				wr_data = {id_q, {ADDR_BITS{1'b0}}, size_q};
			end
			DP_INS_MV, DP_SHF_MV: begin
				wr_en = 1'b1;
			end
			DP_INS_NEW: begin
				wr_en   = 1'b1;
				wr_data = {id_q, best_hs_q, best_hs_q + size_q};
			end
			DP_PCK_MV: begin
				wr_en   = 1'b1;
				wr_data = {r_id, prev_q, prev_q + r_len};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_st) begin
			res_status_q <= cmd.st;
		end
		case (cmd.op)
			DP_LOAD: begin
				act_q        <= req_action;
				id_q         <= req_seg_id & ID_MASK;
				size_q       <= req_seg_size & FIELD_MASK;
				idx_q        <= '0;
				res_status_q <= ST_OK;
				res_start_q  <= '0;
				res_end_q    <= '0;
			end
			DP_ALC_FIRST: begin
				res_end_q <= size_q;
			end
			DP_SCAN_START: begin
				idx_q   <= '0;
				dup_q   <= 1'b0;
				found_q <= 1'b0;
			end
			DP_ALC_EV: begin
				dup_q  <= dup_q || (r_id == id_q);
				prev_q <= r_end;
				idx_q  <= idx_q + CW'(1);
				if (idx_q != '0 && hole_take) begin
					found_q    <= 1'b1;
					best_len_q <= hole_len;
					pos_q      <= hole_pos;
					best_hs_q  <= prev_q;
				end
			end
			DP_ALC_LAST: begin
				if (hole_take) begin
					found_q    <= 1'b1;
					best_len_q <= hole_len;
					pos_q      <= hole_pos;
					best_hs_q  <= prev_q;
				end
			end
			DP_INS_START: begin
				idx_q <= cnt_q;
			end
			DP_INS_MV: begin
				idx_q <= idx_q - CW'(1);
			end
			DP_INS_NEW: begin
				res_start_q <= best_hs_q;
				res_end_q   <= best_hs_q + size_q;
			end
			DP_IDX_INC, DP_SHF_MV: begin
				idx_q <= idx_q + CW'(1);
			end
			DP_PCK_START: begin
				idx_q  <= '0;
				prev_q <= '0;
			end
			DP_PCK_MV: begin
				prev_q <= prev_q + r_len;
				idx_q  <= idx_q + CW'(1);
			end
			DP_RC_START: begin
				idx_q   <= '0;
				acc_q   <= '0;
				awrap_q <= 1'b0;
			end
			DP_RC_EV: begin
				acc_q   <= acc_q + SW'(r_len);
				awrap_q <= awrap_q || (r_end < r_start);
				idx_q   <= idx_q + CW'(1);
			end
			DP_RESULT: begin
				out_status_q <= res_status_q;
				out_start_q  <= res_start_q & FIELD_MASK;
				out_end_q    <= res_end_q & FIELD_MASK;
				out_free_q   <= free_space & FIELD_MASK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			used_q      <= '0;
			uwrap_q     <= 1'b0;
			mem_size_q  <= FIELD_MASK;
			policy_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MEMORY_SIZE: mem_size_q <= cfg_wdata & FIELD_MASK;
					REG_FIT_POLICY:  policy_q   <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			case (cmd.op)
				DP_ALC_FIRST: cnt_q <= CW'(1);
				DP_INS_NEW:   cnt_q <= cnt_q + CW'(1);
				DP_DEC_CNT:   cnt_q <= cnt_q - CW'(1);
				DP_RC_END: begin
					used_q  <= acc_q;
					uwrap_q <= awrap_q;
				end
				default: begin
				end
			endcase
			if (cmd.op == DP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_status    = out_status_q;
	assign rsp_seg_start = out_start_q;
	assign rsp_seg_end   = out_end_q;
	assign rsp_free_left = out_free_q;

	always_comb begin
		stat.action    = act_q;
		stat.nomem     = size_q > free_space;
		stat.empty     = cnt_q == '0;
		stat.full      = cnt_q >= CNT_MAX;
		stat.dup       = dup_q;
		stat.found     = found_q;
		stat.last      = idx_q == cnt_q - CW'(1);
		stat.at_cnt    = idx_q == cnt_q;
		stat.ins_done  = idx_q == pos_q + CW'(1);
		stat.shf_done  = ({1'b0, idx_q} + (CW+1)'(1)) >= {1'b0, cnt_q};
		stat.match     = r_id == id_q;
		stat.out_space = out_space;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("segment count beyond table depth");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_INS_NEW) |-> (cnt_q < CNT_MAX && found_q && !dup_q))
		else $error("insert into a full table or without a chosen hole");

	a_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_RESULT) |=> out_valid_q)
		else $error("result load did not raise the output valid");

endmodule

// File: hw/rtl/contiguous_fit_allocator_unit.sv
// Top level of the contiguous fit allocator: controller, datapath and channel wiring.
// Depends on cfa_pkg, cfa_in_if, cfa_out_if, cfa_ctrl and cfa_dpath.
//
//   channel  | direction | transfer carries
//   ---------+-----------+---------------------------------------------
//   req      | in        | action, seg_id, seg_size
//   rsp      | out       | status, seg_start, seg_end, free_left
//   cfg      | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// One request is handled at a time; the shortest operation is a request rejected at
// once in dispatch, the longest an insert at the head of the table.
// The table memory is read one entry at a time: each entry visit is a read followed
// by a use of the registered entry, for the scan, the entry moves and the space recount.
// Reset clears the table count and the output register at once; no clearing pass.
// A waiting result in the output register does not block the next request.
module contiguous_fit_allocator_unit #(
	parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = cfa_pkg::ADDR_BITS_DEF,
	parameter int ID_BITS      = cfa_pkg::ID_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  cfa_pkg::cfg_reg_t    cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_wdata,
	cfa_in_if.sink               req,
	cfa_out_if.source            rsp
);
	import cfa_pkg::*;

	cfa_cmd_t  cmd;
	cfa_stat_t stat;

	cfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cfa_dpath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_BITS    (ADDR_BITS),
		.ID_BITS      (ID_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.req_action     (req.action),
		.req_seg_id     (req.seg_id),
		.req_seg_size   (req.seg_size),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_status     (rsp.status),
		.rsp_seg_start  (rsp.seg_start),
		.rsp_seg_end    (rsp.seg_end),
		.rsp_free_left  (rsp.free_left),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

// File: tb/contiguous_fit_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of contiguous_fit_allocator_unit: directed and random operations
// are offered on the request channel and every response is checked against a table model.
// Depends on cfa_pkg, cfa_in_if, cfa_out_if and the allocator RTL.
module contiguous_fit_allocator_unit_tb;
	import cfa_pkg::*;

	localparam int NSEG        = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 150;

	typedef struct {
		action_t     act;
		logic [7:0]  id;
		logic [15:0] size;
	} op_item_t;

	typedef struct {
		status_t     st;
		logic [15:0] s;
		logic [15:0] e;
		logic [15:0] fl;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_index = REG_MEMORY_SIZE;
	logic [15:0] cfg_wdata = '0;

	cfa_in_if  req_ch ();
	cfa_out_if rsp_ch ();

	contiguous_fit_allocator_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req_ch), .rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	op_item_t      pending_ops[$];
	alloc_result_t expected_results[$];
	int unsigned   errors = 0;
	int unsigned   cycles = 0;
	int unsigned   send_gap = 0;
	int unsigned   hold = 0;
	bit            quiet = 1'b0;
	bit            squeeze = 1'b0;

	// Shadow copy of the segment table, kept in address order.
	int unsigned tbl_id[NSEG + 1];
	int unsigned tbl_start[NSEG + 1];
	int unsigned tbl_end[NSEG + 1];
	int unsigned seg_cnt = 0;
	int unsigned mem_size = 65535;
	int unsigned free_units = 65535;
	bit          smallest_hole = 1'b0;

	function automatic void recount_free();
		longint unsigned used;
		used = 0;
		for (int i = 0; i < seg_cnt; i++) used += longint'(tbl_end[i] - tbl_start[i]);
		free_units = (used >= mem_size) ? 0 : mem_size - int'(used);
	endfunction

	function automatic status_t place_segment(int unsigned id, int unsigned size,
			output int unsigned s, output int unsigned e);
		int unsigned pos, best_len, hs, he, len;
		bit found;
		pos = 0;
		best_len = 0;
		found = 1'b0;
		s = 0;
		e = 0;
		if (size > free_units) return ST_NOMEM;
		for (int i = 0; i < seg_cnt; i++)
			if (tbl_id[i] == id) return ST_DUP;
		if (seg_cnt == 0) begin
			tbl_id[0] = id;
			tbl_start[0] = 0;
			tbl_end[0] = size;
			seg_cnt = 1;
			e = size;
			return ST_OK;
		end
		if (seg_cnt >= NSEG) return ST_FULL;
		for (int i = 0; i < seg_cnt; i++) begin
			hs = tbl_end[i];
			he = (i + 1 < seg_cnt) ? tbl_start[i + 1] : mem_size;
			if (he < hs) continue;
			len = he - hs;
			if (size > len) continue;
			if (!smallest_hole) begin
				pos = i;
				found = 1'b1;
				break;
			end
			if (!found || len < best_len) begin
				best_len = len;
				pos = i;
				found = 1'b1;
			end
		end
		if (!found) return ST_NOHOLE;
		hs = tbl_end[pos];
		for (int i = seg_cnt; i > pos + 1; i--) begin
			tbl_id[i] = tbl_id[i - 1];
			tbl_start[i] = tbl_start[i - 1];
			tbl_end[i] = tbl_end[i - 1];
		end
		tbl_id[pos + 1] = id;
		tbl_start[pos + 1] = hs;
		tbl_end[pos + 1] = (hs + size) & 16'hFFFF;
		seg_cnt++;
		s = hs;
		e = (hs + size) & 16'hFFFF;
		return ST_OK;
	endfunction

	function automatic status_t release_segment(int unsigned id);
		if (seg_cnt == 0) return ST_EMPTY;
		for (int i = 0; i < seg_cnt; i++) begin
			if (tbl_id[i] == id) begin
				for (int k = i; k + 1 < seg_cnt; k++) begin
					tbl_id[k] = tbl_id[k + 1];
					tbl_start[k] = tbl_start[k + 1];
					tbl_end[k] = tbl_end[k + 1];
				end
				seg_cnt--;
				return ST_OK;
			end
		end
		return ST_NOTFOUND;
	endfunction

	function automatic void predict_allocation(op_item_t it);
		alloc_result_t r;
		int unsigned s, e, prev, len;
		s = 0;
		e = 0;
		r.st = ST_OK;
		case (it.act)
			ACT_ALLOC: r.st = place_segment(it.id, it.size, s, e);
			ACT_FREE:  r.st = release_segment(it.id);
			ACT_PACK: begin
				prev = 0;
				for (int i = 0; i < seg_cnt; i++) begin
					len = tbl_end[i] - tbl_start[i];
					tbl_start[i] = prev;
					tbl_end[i] = (prev + len) & 16'hFFFF;
					prev = tbl_end[i];
				end
			end
			default: ;
		endcase
		recount_free();
		r.s = s[15:0];
		r.e = e[15:0];
		r.fl = free_units[15:0];
		expected_results.push_back(r);
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		errors++;
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 999);
		if (r < 10) quiet = ~quiet;
		if (quiet) return 0;
		r = r % 100;
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("contiguous_fit_allocator_unit: mismatch");
			$finish;
		end
	end

	// Request driver: one transfer per accepted item, random gaps in between.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				predict_allocation(pending_ops[0]);
				void'(pending_ops.pop_front());
				send_gap = pick_gap();
			end
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.action <= pending_ops[0].act;
				req_ch.seg_id <= pending_ops[0].id;
				req_ch.seg_size <= pending_ops[0].size;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response monitor and back-pressure.
	always @(posedge clk) begin : monitor
		alloc_result_t w;
		int unsigned r;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected transfer, status", rsp_ch.status, 0);
				end else begin
					w = expected_results.pop_front();
					if (rsp_ch.status !== w.st) report("status", rsp_ch.status, w.st);
					if (rsp_ch.seg_start !== w.s) report("seg_start", rsp_ch.seg_start, w.s);
					if (rsp_ch.seg_end !== w.e) report("seg_end", rsp_ch.seg_end, w.e);
					if (rsp_ch.free_left !== w.fl) report("free_left", rsp_ch.free_left, w.fl);
				end
			end
			r = $urandom_range(0, 99);
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (squeeze) begin
				squeeze = 1'b0;
				hold = 600;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && r < 2) begin
				hold = $urandom_range(20, 60);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= quiet || r < 75;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[15:0];
		if (idx == REG_MEMORY_SIZE) begin
			mem_size = value & 16'hFFFF;
			recount_free();
		end else begin
			smallest_hole = value[0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic void queue_op(action_t act, int unsigned id, int unsigned size);
		op_item_t it;
		it.act = act;
		it.id = id[7:0];
		it.size = size[15:0];
		pending_ops.push_back(it);
	endfunction

	function automatic void queue_random(int unsigned count, int unsigned mem);
		int unsigned r, id, size;
		action_t act;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			act = (r < 50) ? ACT_ALLOC : (r < 85) ? ACT_FREE : (r < 95) ? ACT_PACK : ACT_NONE;
			id = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 19) : $urandom_range(0, 255);
			r = $urandom_range(0, 99);
			if (r < 80) size = $urandom_range(0, mem / 8 + 1);
			else if (r < 90) size = $urandom_range(0, mem);
			else size = $urandom_range(0, 65535);
			queue_op(act, id, size);
		end
	endfunction

	initial begin
		req_ch.valid = 1'b0;
		req_ch.action = ACT_NONE;
		req_ch.seg_id = '0;
		req_ch.seg_size = '0;
		rsp_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty table cases, zero size, full range, duplicate, unused code.
		queue_op(ACT_FREE, 3, 0);
		queue_op(ACT_PACK, 0, 0);
		queue_op(ACT_NONE, 255, 65535);
		queue_op(ACT_ALLOC, 0, 0);
		queue_op(ACT_ALLOC, 0, 5);
		queue_op(ACT_ALLOC, 255, 65535);
		queue_op(ACT_ALLOC, 1, 1);
		queue_op(ACT_FREE, 7, 0);
		queue_op(ACT_FREE, 0, 0);
		queue_op(ACT_FREE, 255, 0);
		for (int i = 0; i < 17; i++) queue_op(ACT_ALLOC, 10 + i, 100 + i);
		queue_op(ACT_FREE, 10, 0);
		queue_op(ACT_FREE, 14, 0);
		queue_op(ACT_ALLOC, 40, 50);
		queue_op(ACT_PACK, 0, 0);
		wait_idle();

		write_reg(REG_FIT_POLICY, 1);
		queue_random(250, 65535);
		squeeze = 1'b1;
		wait_idle();

		write_reg(REG_MEMORY_SIZE, 300);
		queue_random(250, 300);
		wait_idle();

		write_reg(REG_MEMORY_SIZE, 1);
		write_reg(REG_FIT_POLICY, 0);
		queue_random(100, 1);
		wait_idle();

		write_reg(REG_MEMORY_SIZE, 5000);
		for (int i = 0; i < 12; i++) queue_op(ACT_ALLOC, 100 + i, $urandom_range(50, 400));
		wait_idle();
		// Shrink below the end of stored segments so that holes fall outside memory.
		write_reg(REG_MEMORY_SIZE, 700);
		queue_random(150, 700);
		wait_idle();

		write_reg(REG_MEMORY_SIZE, 65535);
		write_reg(REG_FIT_POLICY, 1);
		queue_random(250, 65535);
		wait_idle();

		write_reg(REG_MEMORY_SIZE, 1000);
		write_reg(REG_FIT_POLICY, 0);
		queue_random(250, 1000);
		wait_idle();

		if (errors == 0) begin
			$display("contiguous_fit_allocator_unit: match");
		end else begin
			$display("contiguous_fit_allocator_unit: mismatch");
		end
		$finish;
	end
endmodule

// File: contiguous_fit_allocator_unit.f
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_in_if.sv
hw/rtl/cfa_out_if.sv
hw/rtl/cfa_ctrl.sv
hw/rtl/cfa_dpath.sv
hw/rtl/contiguous_fit_allocator_unit.sv
tb/contiguous_fit_allocator_unit_tb.sv
